// ===== rtl/djt_pkg.sv =====
// Shared constants and types for the joint transform pipeline.
// Used by every module of the block; depends on nothing.
package djt_pkg;

  // Pipeline depths of the parts.
  localparam int PHASE_STAGES = 3;
  localparam int CORDIC_STEPS = 30;
  localparam int MUL_STAGES = 2;

  // Start value of the CORDIC x path: the inverse gain in Q2.30.
  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  // About 2^64 / (2*pi); turns radians into a fraction of a turn.
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'd2935890503282001226;

  // Arctangent of 2^-i as a fraction of a turn, 2^32 per turn.
  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_JOINT_KIND     = 3'd0,
    CFG_FIXED_THETA    = 3'd1,
    CFG_FIXED_OFFSET_D = 3'd2,
    CFG_TWIST_ALPHA    = 3'd3,
    CFG_LINK_LENGTH_A  = 3'd4
  } cfg_idx_t;

endpackage

// ===== rtl/djt_phase.sv =====
// Angle to phase reduction: radians times 1/(2*pi), folded to the right half plane.
// Three register stages; depends on djt_pkg.
module djt_phase import djt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic [PHASE_STAGES-1:0] en,
  input  logic signed [31:0]      angle,
  output logic signed [31:0]      phase_z,
  output logic                    phase_flip
);

  localparam logic [63:0] KP = INV_TWO_PI_Q64 >> FRAC_BITS;
  localparam logic [23:0] KP_LO = KP[23:0];
  localparam logic [31:0] KP_HI = 32'(KP >> 24);

  logic signed [56:0] plo_nxt, plo_r;
  logic signed [64:0] phi_full;
  logic [39:0]        phi_r;
  logic [63:0]        sum;
  logic [31:0]        phase_r;
  logic               flip;
  logic signed [31:0] z_r;
  logic               flip_r;

  // Stage one: two partial products of the angle and the turn constant.
  assign plo_nxt  = angle * $signed({1'b0, KP_LO});
  assign phi_full = angle * $signed({1'b0, KP_HI});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo_r <= plo_nxt;
      phi_r <= phi_full[39:0];
    end
  end

  // Stage two: combine the partial products, keep the upper word as phase.
  assign sum = {{7{plo_r[56]}}, plo_r} + {phi_r, 24'b0};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      phase_r <= sum[63:32];
    end
  end

  // Stage three: rotate the second and third quadrants by half a turn.
  assign flip = phase_r[31] ^ phase_r[30];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      z_r    <= $signed({phase_r[31] ^ flip, phase_r[30:0]});
      flip_r <= flip;
    end
  end

  assign phase_z    = z_r;
  assign phase_flip = flip_r;

endmodule

// ===== rtl/djt_cordic.sv =====
// Pipelined rotation-mode CORDIC, one stage per step, plus a rounding stage.
// Produces cosine and sine in Q1.FRAC_BITS; depends on djt_pkg.
module djt_cordic import djt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int RW = FRAC_BITS + 2
) (
  input  logic                    clk,
  input  logic [CORDIC_STEPS:0]   en,
  input  logic signed [31:0]      angle_z,
  input  logic                    angle_flip,
  output logic signed [RW-1:0]    cos_out,
  output logic signed [RW-1:0]    sin_out
);

  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [XW:0] HALF_W = (XW+1)'(2**(SH-1));
  localparam logic signed [XW:0] ONE_W = (XW+1)'(2**FRAC_BITS);
  localparam logic signed [XW:0] NEG_ONE_W = -ONE_W;

  logic signed [XW-1:0] x_r [CORDIC_STEPS];
  logic signed [XW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];
  logic                 flip_r [CORDIC_STEPS];

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] x_in, y_in;
    logic signed [ZW-1:0] z_in, atan_w;
    logic                 f_in;

    if (i == 0) begin : g_first
      assign x_in = XW'(CORDIC_X0);
      assign y_in = '0;
      assign z_in = {angle_z[31], angle_z};
      assign f_in = angle_flip;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign f_in = flip_r[i-1];
    end

    assign atan_w = $signed({3'b000, ATAN_TURNS[i]});

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (!z_in[ZW-1]) begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - atan_w;
        end else begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + atan_w;
        end
        flip_r[i] <= f_in;
      end
    end
  end

  // Undo the half-turn fold, round half up to FRAC_BITS and clamp to one.
  logic signed [XW:0]   xn, yn, xs, ys;
  logic signed [RW-1:0] cos_nxt, sin_nxt, cos_r, sin_r;

  always_comb begin
    xn = {x_r[CORDIC_STEPS-1][XW-1], x_r[CORDIC_STEPS-1]};
    yn = {y_r[CORDIC_STEPS-1][XW-1], y_r[CORDIC_STEPS-1]};
    if (flip_r[CORDIC_STEPS-1]) begin
      xn = -xn;
      yn = -yn;
    end
    xs = (xn + HALF_W) >>> SH;
    ys = (yn + HALF_W) >>> SH;
    if (xs > ONE_W) begin
      cos_nxt = RW'(ONE_W);
    end else if (xs < NEG_ONE_W) begin
      cos_nxt = RW'(NEG_ONE_W);
    end else begin
      cos_nxt = RW'(xs);
    end
    if (ys > ONE_W) begin
      sin_nxt = RW'(ONE_W);
    end else if (ys < NEG_ONE_W) begin
      sin_nxt = RW'(NEG_ONE_W);
    end else begin
      sin_nxt = RW'(ys);
    end
  end

  always_ff @(posedge clk) begin
    if (en[CORDIC_STEPS]) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

// ===== rtl/djt_outmul.sv =====
// Product and rounding stages that form the rotation entries and translation.
// The second stage is the output register; depends on djt_pkg.
module djt_outmul import djt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int RW = FRAC_BITS + 2
) (
  input  logic                  clk,
  input  logic [MUL_STAGES-1:0] en,
  input  logic signed [RW-1:0]  st,
  input  logic signed [RW-1:0]  ct,
  input  logic signed [RW-1:0]  sa,
  input  logic signed [RW-1:0]  ca,
  input  logic signed [31:0]    len_a,
  input  logic signed [31:0]    off_d,
  output logic signed [RW-1:0]  r00,
  output logic signed [RW-1:0]  r01,
  output logic signed [RW-1:0]  r02,
  output logic signed [RW-1:0]  r10,
  output logic signed [RW-1:0]  r11,
  output logic signed [RW-1:0]  r12,
  output logic signed [RW-1:0]  r21,
  output logic signed [RW-1:0]  r22,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic signed [31:0]    pos_z
);

  localparam int QW = 2 * RW;
  localparam int PW = 32 + RW + 1;
  localparam logic signed [QW:0] HALF_Q = (QW+1)'(2**(FRAC_BITS-1));
  localparam logic signed [PW-1:0] HALF_P = PW'(2**(FRAC_BITS-1));
  localparam logic signed [PW-1:0] PMAX = PW'(32'h7FFF_FFFF);
  localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);

  logic signed [QW-1:0] psc_r, pss_r, pcc_r, pcs_r;
  logic signed [PW-2:0] pax_r, pay_r;
  logic signed [RW-1:0] st_r, ct_r, sa_r, ca_r;
  logic signed [31:0]   d_r;

  // Stage one: all products, each into its own register.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      psc_r <= st * ca;
      pss_r <= st * sa;
      pcc_r <= ct * ca;
      pcs_r <= ct * sa;
      pax_r <= len_a * ct;
      pay_r <= len_a * st;
      st_r  <= st;
      ct_r  <= ct;
      sa_r  <= sa;
      ca_r  <= ca;
      d_r   <= off_d;
    end
  end

  function automatic logic signed [RW-1:0] rnd_rot(input logic signed [QW-1:0] p);
    logic signed [QW:0] t;
    t = ($signed({p[QW-1], p}) + HALF_Q) >>> FRAC_BITS;
    return RW'(t);
  endfunction

  function automatic logic signed [31:0] rnd_pos(input logic signed [PW-2:0] p);
    logic signed [PW-1:0] t;
    t = ($signed({p[PW-2], p}) + HALF_P) >>> FRAC_BITS;
    if (t > PMAX) begin
      t = PMAX;
    end else if (t < PMIN) begin
      t = PMIN;
    end
    return 32'(t);
  endfunction

  logic signed [RW-1:0] r01_nxt, r02_nxt, r11_nxt, r12_nxt;
  logic signed [31:0]   px_nxt, py_nxt;

  // Stage two: round products half up, clamp the translation to 32 bits, negate where the matrix needs it.
  always_comb begin
    r01_nxt = -rnd_rot(psc_r);
    r02_nxt = rnd_rot(pss_r);
    r11_nxt = rnd_rot(pcc_r);
    r12_nxt = -rnd_rot(pcs_r);
    px_nxt  = rnd_pos(pax_r);
    py_nxt  = rnd_pos(pay_r);
  end

  logic signed [RW-1:0] r00_r, r01_r, r02_r, r10_r, r11_r, r12_r, r21_r, r22_r;
  logic signed [31:0]   px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r00_r <= ct_r;
      r01_r <= r01_nxt;
      r02_r <= r02_nxt;
      r10_r <= st_r;
      r11_r <= r11_nxt;
      r12_r <= r12_nxt;
      r21_r <= sa_r;
      r22_r <= ca_r;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= d_r;
    end
  end

  assign r00   = r00_r;
  assign r01   = r01_r;
  assign r02   = r02_r;
  assign r10   = r10_r;
  assign r11   = r11_r;
  assign r12   = r12_r;
  assign r21   = r21_r;
  assign r22   = r22_r;
  assign pos_x = px_r;
  assign pos_y = py_r;
  assign pos_z = pz_r;

endmodule

// ===== rtl/dh_joint_transform_unit.sv =====
// Denavit-Hartenberg link transform, one joint value per word.
// An accepted input word passes through 3 phase stages, 30 CORDIC stages, a
// rounding stage and two product stages on its way to its result word.
// Throughput: one word per cycle; each stage moves when the stage after it is
// free, so bubbles close up while a result waits and the input stalls only once
// all 36 stages hold a word.
// Reset (rst_n low, synchronous) empties the pipeline by clearing the valid
// bits and sets the configuration registers to zero; data registers keep their
// contents.
module dh_joint_transform_unit import djt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int RW = FRAC_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_joint_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [RW-1:0] out_r00,
  output logic signed [RW-1:0] out_r01,
  output logic signed [RW-1:0] out_r02,
  output logic signed [RW-1:0] out_r10,
  output logic signed [RW-1:0] out_r11,
  output logic signed [RW-1:0] out_r12,
  output logic signed [RW-1:0] out_r21,
  output logic signed [RW-1:0] out_r22,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CARRY = PHASE_STAGES + CORDIC_STEPS + 1;
  localparam int NST = CARRY + MUL_STAGES;
  localparam logic signed [RW-1:0] ONE_R = RW'(2**FRAC_BITS);
  localparam logic signed [RW-1:0] NEG_ONE_R = -ONE_R;

  // Configuration registers.
  logic               kind_r;
  logic signed [31:0] theta_r, offd_r, alpha_r, lena_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= 1'b0;
      theta_r <= '0;
      offd_r  <= '0;
      alpha_r <= '0;
      lena_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_JOINT_KIND:     kind_r  <= cfg_data[0];
        CFG_FIXED_THETA:    theta_r <= cfg_data;
        CFG_FIXED_OFFSET_D: offd_r  <= cfg_data;
        CFG_TWIST_ALPHA:    alpha_r <= cfg_data;
        CFG_LINK_LENGTH_A:  lena_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits and the per-stage advance chain.
  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   ready;

  always_comb begin
    ready[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      ready[k] = !vld_r[k] || ready[k+1];
    end
    vld_nxt[0] = ready[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = ready[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld_r[NST-1];

  // Pick theta and d by joint kind.
  logic signed [31:0] theta_in, d_in;
  assign theta_in = kind_r ? theta_r : in_joint_value;
  assign d_in     = kind_r ? in_joint_value : offd_r;

  // Carry a and d alongside the angle pipeline.
  logic signed [31:0] d_pipe_r [CARRY];
  logic signed [31:0] a_pipe_r [CARRY];

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      d_pipe_r[0] <= d_in;
      a_pipe_r[0] <= lena_r;
    end
    for (int k = 1; k < CARRY; k++) begin
      if (ready[k]) begin
        d_pipe_r[k] <= d_pipe_r[k-1];
        a_pipe_r[k] <= a_pipe_r[k-1];
      end
    end
  end

  // Theta and alpha each get a phase reducer and a CORDIC.
  logic signed [31:0]   th_z, al_z;
  logic                 th_flip, al_flip;
  logic signed [RW-1:0] st, ct, sa, ca;

  djt_phase #(.FRAC_BITS(FRAC_BITS)) u_th_phase (
    .clk(clk), .en(ready[PHASE_STAGES-1:0]), .angle(theta_in),
    .phase_z(th_z), .phase_flip(th_flip)
  );

  djt_phase #(.FRAC_BITS(FRAC_BITS)) u_al_phase (
    .clk(clk), .en(ready[PHASE_STAGES-1:0]), .angle(alpha_r),
    .phase_z(al_z), .phase_flip(al_flip)
  );

  djt_cordic #(.FRAC_BITS(FRAC_BITS)) u_th_cordic (
    .clk(clk), .en(ready[PHASE_STAGES +: CORDIC_STEPS+1]),
    .angle_z(th_z), .angle_flip(th_flip), .cos_out(ct), .sin_out(st)
  );

  djt_cordic #(.FRAC_BITS(FRAC_BITS)) u_al_cordic (
    .clk(clk), .en(ready[PHASE_STAGES +: CORDIC_STEPS+1]),
    .angle_z(al_z), .angle_flip(al_flip), .cos_out(ca), .sin_out(sa)
  );

  // Products, rounding and the output register.
  djt_outmul #(.FRAC_BITS(FRAC_BITS)) u_outmul (
    .clk(clk), .en(ready[CARRY +: MUL_STAGES]),
    .st(st), .ct(ct), .sa(sa), .ca(ca),
    .len_a(a_pipe_r[CARRY-1]), .off_d(d_pipe_r[CARRY-1]),
    .r00(out_r00), .r01(out_r01), .r02(out_r02), .r10(out_r10),
    .r11(out_r11), .r12(out_r12), .r21(out_r21), .r22(out_r22),
    .pos_x(out_pos_x), .pos_y(out_pos_y), .pos_z(out_pos_z)
  );

  // An accepted word lands in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted word did not enter the pipeline");

  // A stalled result word is never dropped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result word was lost");

  // Cosine and sine leave clamped to plus or minus one.
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r00 <= ONE_R && out_r00 >= NEG_ONE_R))
    else $error("cosine out of range");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r21 <= ONE_R && out_r21 >= NEG_ONE_R))
    else $error("sine of twist out of range");

endmodule

// ===== dv/dh_joint_transform_unit_test.sv =====
// Self-checking testbench for dh_joint_transform_unit: drives joint words, predicts each
// link transform in fixed point and compares every result word field by field.
// Depends on djt_pkg and the RTL of dh_joint_transform_unit.
`timescale 1ns / 1ps
module dh_joint_transform_unit_test;
  import djt_pkg::*;

  localparam int FRAC = 16;
  localparam int RW = FRAC + 2;
  localparam int LATENCY = 36;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [RW-1:0] r00, r01, r02, r10, r11, r12, r21, r22;
    logic signed [31:0] pos_x, pos_y, pos_z;
  } link_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_joint_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RW-1:0] out_r00, out_r01, out_r02, out_r10, out_r11, out_r12, out_r21, out_r22;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic        kind_q;
  logic [31:0] theta_q, offset_q, alpha_q, length_q;

  link_frame_t frame_queue[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  dh_joint_transform_unit #(.FRAC_BITS(FRAC)) i_dut (.*);

  function automatic longint round_frac(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Phase reduction, quadrant fold and a 30-step CORDIC rotation.
  task automatic sin_cos(input logic signed [31:0] ang, output longint s, output longint c);
    logic [63:0] kp, prod;
    logic [31:0] phase;
    logic flip;
    longint x, y, z, dx, dy;
    longint one;
    kp = INV_TWO_PI_Q64 >> FRAC;
    prod = 64'(longint'(ang)) * kp;
    phase = prod[63:32];
    flip = phase[31] ^ phase[30];
    if (flip) phase = phase + 32'h8000_0000;
    x = longint'(CORDIC_X0);
    y = 0;
    z = longint'($signed(phase));
    one = 64'sd1 <<< FRAC;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(round_frac(x, 30 - FRAC), -one, one);
    s = clip(round_frac(y, 30 - FRAC), -one, one);
  endtask

  task automatic predict_frame(input logic signed [31:0] jv);
    longint theta, d, st, ct, sa, ca, a;
    link_frame_t f;
    if (kind_q) begin
      theta = longint'($signed(theta_q)); d = jv;
    end else begin
      theta = jv; d = longint'($signed(offset_q));
    end
    a = longint'($signed(length_q));
    sin_cos(32'(theta), st, ct);
    sin_cos(alpha_q, sa, ca);
    f.r00 = RW'(ct);
    f.r01 = RW'(-round_frac(st * ca, FRAC));
    f.r02 = RW'(round_frac(st * sa, FRAC));
    f.r10 = RW'(st);
    f.r11 = RW'(round_frac(ct * ca, FRAC));
    f.r12 = RW'(-round_frac(ct * sa, FRAC));
    f.r21 = RW'(sa);
    f.r22 = RW'(ca);
    f.pos_x = 32'(clip(round_frac(a * ct, FRAC), -64'sd2147483648, 64'sd2147483647));
    f.pos_y = 32'(clip(round_frac(a * st, FRAC), -64'sd2147483648, 64'sd2147483647));
    f.pos_z = 32'(d);
    frame_queue.push_back(f);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    link_frame_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_queue.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = frame_queue.pop_front();
        if (out_r00 !== e.r00) report_mismatch("r00", out_r00, e.r00);
        if (out_r01 !== e.r01) report_mismatch("r01", out_r01, e.r01);
        if (out_r02 !== e.r02) report_mismatch("r02", out_r02, e.r02);
        if (out_r10 !== e.r10) report_mismatch("r10", out_r10, e.r10);
        if (out_r11 !== e.r11) report_mismatch("r11", out_r11, e.r11);
        if (out_r12 !== e.r12) report_mismatch("r12", out_r12, e.r12);
        if (out_r21 !== e.r21) report_mismatch("r21", out_r21, e.r21);
        if (out_r22 !== e.r22) report_mismatch("r22", out_r22, e.r22);
        if (out_pos_x !== e.pos_x) report_mismatch("pos_x", out_pos_x, e.pos_x);
        if (out_pos_y !== e.pos_y) report_mismatch("pos_y", out_pos_y, e.pos_y);
        if (out_pos_z !== e.pos_z) report_mismatch("pos_z", out_pos_z, e.pos_z);
      end
    end
  end

  // Receiver stall: random, or a long hold counted in cycles.
  always @(posedge clk) begin
    int hold_count;
    if (long_hold) begin
      hold_count++;
      out_stall <= (hold_count < 300);
    end else begin
      hold_count = 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles with no accepted word and no taken result word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("dh_joint_transform_unit_test: FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic signed [31:0] jv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_value <= jv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(jv);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (frame_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_JOINT_KIND:     kind_q = v[0];
      CFG_FIXED_THETA:    theta_q = v;
      CFG_FIXED_OFFSET_D: offset_q = v;
      CFG_TWIST_ALPHA:    alpha_q = v;
      CFG_LINK_LENGTH_A:  length_q = v;
      default: ;
    endcase
  endtask

  task automatic set_link(input logic kind, input logic [31:0] th, input logic [31:0] d,
                          input logic [31:0] al, input logic [31:0] a);
    write_reg(CFG_JOINT_KIND, {$urandom} & ~32'd1 | 32'(kind));
    write_reg(CFG_FIXED_THETA, th);
    write_reg(CFG_FIXED_OFFSET_D, d);
    write_reg(CFG_TWIST_ALPHA, al);
    write_reg(CFG_LINK_LENGTH_A, a);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(823550)) - 411775);
      2: return {$urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000};
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // Extremes, quadrant boundaries and both joint kinds.
  task automatic test_directed();
    logic [31:0] vals[12] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1,
                              32'd102944, 32'd205887, 32'd308831, 32'd411775,
                              -32'sd102944, 32'h5555_5555, 32'hAAAA_AAAA};
    set_link(1'b0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    foreach (vals[i]) send_word(vals[i]);
    drain_results();
    set_link(1'b1, 32'd205887, 32'h8000_0000, 32'd102944, 32'h7FFF_FFFF);
    foreach (vals[i]) send_word(vals[i]);
    drain_results();
  endtask

  task automatic test_random(input int sidle, input int rstall, input int n);
    send_idle_pct = sidle;
    stall_pct = rstall;
    set_link($urandom_range(1), rand_word(), rand_word(), rand_word(), rand_word());
    for (int i = 0; i < n; i++) send_word(rand_word());
    drain_results();
  endtask

  // Long receiver hold while words keep coming, a pause until drained, then more words without the hold.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    for (int i = 0; i < 120; i++) send_word(rand_word());
    drain_results();
    long_hold = 1'b0;
    for (int i = 0; i < 40; i++) send_word(rand_word());
    drain_results();
  endtask

  initial begin
    kind_q = 1'b0; theta_q = '0; offset_q = '0; alpha_q = '0; length_q = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: test_random(0, 0, 90);
        1: test_random(69, 0, 90);
        2: test_random(0, 69, 90);
        default: test_random(25, 25, 90);
      endcase
    end
    test_back_pressure();
    if (fail_count == 0) $display("dh_joint_transform_unit_test: PASS");
    else $display("dh_joint_transform_unit_test: FAIL");
    $finish;
  end

endmodule
